FILE: hw/rtl/lgti_pkg.sv
// ----------------------------------------------------------------------------
// Lazy grid trilinear interpolator package
// Shared grid constants, codes, memory request type and index helpers.
// ----------------------------------------------------------------------------
package lgti_pkg;

  localparam int GRID_X         = 16;
  localparam int GRID_Y         = 16;
  localparam int GRID_Z         = 16;
  localparam int MAX_COMPONENTS = 8;

  localparam int NUM_POINTS  = GRID_X * GRID_Y * GRID_Z;
  localparam int NUM_SAMPLES = NUM_POINTS * MAX_COMPONENTS;
  localparam int PT_W        = $clog2(NUM_POINTS);
  localparam int SA_W        = $clog2(NUM_SAMPLES);

  localparam int DEN_W     = 31;
  localparam int NUM_W     = 48;
  localparam int FRAC_W    = 16;
  localparam int MID_ITER  = NUM_W - FRAC_W;
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam int CFG_IDX_W = 3;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    STS_WR_OK     = 3'd0,
    STS_WR_REJECT = 3'd1,
    STS_RANGE     = 3'd2,
    STS_MISSING   = 3'd3,
    STS_VALUE     = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_ORIGIN_Z   = 3'd2,
    CFG_STEP_X     = 3'd3,
    CFG_STEP_Y     = 3'd4,
    CFG_STEP_Z     = 3'd5,
    CFG_COMPONENTS = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_CHK,
    ST_EMIT_ONE,
    ST_LOC_START,
    ST_LOC_WAIT,
    ST_VCHK,
    ST_MISS,
    ST_LOAD,
    ST_BL_MUL,
    ST_BL_ADD,
    ST_VAL_EMIT
  } state_e;

  typedef struct packed {
    logic            v_en;
    logic            v_we;
    logic [PT_W-1:0] v_addr;
    logic            v_wdata;
    logic            s_en;
    logic            s_we;
    logic [SA_W-1:0] s_addr;
    logic [31:0]     s_wdata;
  } mem_req_t;

  function automatic logic [PT_W-1:0] point_index(logic [5:0] ix, logic [5:0] iy,
                                                  logic [5:0] iz);
    point_index = PT_W'((int'(ix) * GRID_Y + int'(iy)) * GRID_Z + int'(iz));
  endfunction

  function automatic logic [SA_W-1:0] sample_addr(logic [PT_W-1:0] pt, logic [2:0] comp);
    sample_addr = SA_W'(int'(pt) * MAX_COMPONENTS + int'(comp));
  endfunction

  function automatic logic [DEN_W-1:0] step_eff(logic [DEN_W-1:0] s);
    step_eff = (s == '0) ? DEN_W'(1) : s;
  endfunction

endpackage

FILE: hw/rtl/lazy_grid_trilinear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// Lazy grid trilinear interpolator
// Sequencer with a shared blend unit over a lazily filled vector grid.
// ----------------------------------------------------------------------------
// After reset the block sweeps the point valid memory, one point per cycle,
// before it takes the first request. A write request reads the point's
// valid mark, then writes the sample (and the mark on the final component)
// only if the point is not yet valid. An evaluate request locates the cell
// with one shared serial divider, axis by axis, then reads the eight valid
// marks; each missing corner then gives one result. With all corners present,
// each component takes eight sample reads and seven blends through one
// multiplier, each blend a multiply step and an add step. A result register
// lets the next request enter while the last result waits.
module lazy_grid_trilinear_interpolator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [5:0]  write_ix_i,
  input  logic [5:0]  write_iy_i,
  input  logic [5:0]  write_iz_i,
  input  logic [2:0]  component_i,
  input  logic [31:0] sample_i,
  input  logic        final_component_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [5:0]  corner_ix_o,
  output logic [5:0]  corner_iy_o,
  output logic [5:0]  corner_iz_o,
  output logic [31:0] corner_pos_x_o,
  output logic [31:0] corner_pos_y_o,
  output logic [31:0] corner_pos_z_o,
  output logic [2:0]  out_component_o,
  output logic [31:0] result_value_o,
  output logic        last_o
);

  lgti_pkg::state_e state_q, state_d;

  logic [31:0] origin_x_q, origin_y_q, origin_z_q;
  logic [30:0] step_x_q, step_y_q, step_z_q;
  logic [3:0]  comps_q;

  logic [31:0]                pos_x_q, pos_y_q, pos_z_q;
  logic [5:0]                 wix_q, wiy_q, wiz_q;
  logic [2:0]                 wcomp_q;
  logic [31:0]                sample_q;
  logic                       final_q;
  logic [2:0]                 status_q;
  logic [1:0]                 axis_q;
  logic [5:0]                 cell_x_q, cell_y_q, cell_z_q;
  logic [15:0]                t_x_q, t_y_q, t_z_q;
  logic [31:0]                base_x_q, base_y_q, base_z_q;
  logic [7:0]                 mask_q;
  logic [3:0]                 n_q;
  logic [2:0]                 comp_q;
  logic [31:0]                queue_q [8];
  logic [3:0]                 qcnt_q;
  logic [2:0]                 bc_q;
  logic [31:0]                a_q;
  logic [49:0]                prod_q;
  logic [lgti_pkg::PT_W-1:0]  clr_q;

  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [5:0]  out_ix_q, out_iy_q, out_iz_q;
  logic [31:0] out_px_q, out_py_q, out_pz_q;
  logic [2:0]  out_comp_q;
  logic [31:0] out_value_q;
  logic        out_last_q;

  logic [2:0]  out_status_d;
  logic [5:0]  out_ix_d, out_iy_d, out_iz_d;
  logic [31:0] out_px_d, out_py_d, out_pz_d;
  logic [2:0]  out_comp_d;
  logic [31:0] out_value_d;
  logic        out_last_d;
  logic        out_load;
  logic        out_free;

  lgti_pkg::mem_req_t mem_req;
  logic               v_rdata;
  logic [31:0]        s_rdata;

  logic                          div_start;
  logic                          div_done;
  logic [lgti_pkg::NUM_W-1:0]    div_quot;
  logic [lgti_pkg::DEN_W-1:0]    div_rem;

  logic [31:0] pos_sel, org_sel;
  logic [30:0] step_sel;
  logic [31:0] grid_m1;
  logic [32:0] d_sel;
  logic [2:0]  nl;
  logic [2:0]  nm1;
  logic [5:0]  vx, vy, vz;
  logic [5:0]  lx, ly, lz;
  logic [5:0]  mx, my, mz;
  logic [7:0]  remaining;
  logic        miss_last;
  logic        in_grid;
  logic [3:0]  ncomp;
  logic        comp_last;
  logic [15:0] t_sel;
  logic [32:0] diff;
  logic [33:0] blend_sum;
  logic [31:0] blend_res;
  logic        accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      step_x_q   <= 31'd65536;
      step_y_q   <= 31'd65536;
      step_z_q   <= 31'd65536;
      comps_q    <= 4'd1;
    end else if (cfg_valid_i) begin
      case (lgti_pkg::cfg_idx_e'(cfg_index_i))
        lgti_pkg::CFG_ORIGIN_X:   origin_x_q <= cfg_data_i;
        lgti_pkg::CFG_ORIGIN_Y:   origin_y_q <= cfg_data_i;
        lgti_pkg::CFG_ORIGIN_Z:   origin_z_q <= cfg_data_i;
        lgti_pkg::CFG_STEP_X:     step_x_q   <= cfg_data_i[30:0];
        lgti_pkg::CFG_STEP_Y:     step_y_q   <= cfg_data_i[30:0];
        lgti_pkg::CFG_STEP_Z:     step_z_q   <= cfg_data_i[30:0];
        lgti_pkg::CFG_COMPONENTS: comps_q    <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (axis_q)
      2'd0: begin
        pos_sel  = pos_x_q;
        org_sel  = origin_x_q;
        step_sel = lgti_pkg::step_eff(step_x_q);
        grid_m1  = 32'(lgti_pkg::GRID_X - 1);
      end
      2'd1: begin
        pos_sel  = pos_y_q;
        org_sel  = origin_y_q;
        step_sel = lgti_pkg::step_eff(step_y_q);
        grid_m1  = 32'(lgti_pkg::GRID_Y - 1);
      end
      default: begin
        pos_sel  = pos_z_q;
        org_sel  = origin_z_q;
        step_sel = lgti_pkg::step_eff(step_z_q);
        grid_m1  = 32'(lgti_pkg::GRID_Z - 1);
      end
    endcase
    d_sel = {pos_sel[31], pos_sel} - {org_sel[31], org_sel};

    nl  = n_q[2:0];
    nm1 = 3'(n_q - 4'd1);
    vx  = cell_x_q + 6'(nl[2]);
    vy  = cell_y_q + 6'(nl[1]);
    vz  = cell_z_q + 6'(nl[0]);
    lx  = cell_x_q + 6'(nl[0]);
    ly  = cell_y_q + 6'(nl[1]);
    lz  = cell_z_q + 6'(nl[2]);

    remaining = ~mask_q & (8'hFE << nl);
    miss_last = (remaining == 8'd0);

    in_grid = (7'(write_ix_i) < 7'(lgti_pkg::GRID_X)) &&
              (7'(write_iy_i) < 7'(lgti_pkg::GRID_Y)) &&
              (7'(write_iz_i) < 7'(lgti_pkg::GRID_Z));

    if (comps_q == 4'd0) begin
      ncomp = 4'd1;
    end else if (comps_q > 4'(lgti_pkg::MAX_COMPONENTS)) begin
      ncomp = 4'(lgti_pkg::MAX_COMPONENTS);
    end else begin
      ncomp = comps_q;
    end
    comp_last = (4'(comp_q) == ncomp - 4'd1);

    if (bc_q < 3'd4) begin
      t_sel = t_x_q;
    end else if (bc_q < 3'd6) begin
      t_sel = t_y_q;
    end else begin
      t_sel = t_z_q;
    end
    diff      = {queue_q[1][31], queue_q[1]} - {queue_q[0][31], queue_q[0]};
    blend_sum = {{2{a_q[31]}}, a_q} + 34'($signed(prod_q) >>> 16);
    blend_res = blend_sum[31:0];
  end

  assign mx = cell_x_q + 6'(nl[2]);
  assign my = cell_y_q + 6'(nl[1]);
  assign mz = cell_z_q + 6'(nl[0]);

  always_comb begin
    state_d      = state_q;
    in_stall_o   = 1'b1;
    div_start    = 1'b0;
    out_load     = 1'b0;
    mem_req      = '0;
    out_status_d = status_q;
    out_ix_d     = '0;
    out_iy_d     = '0;
    out_iz_d     = '0;
    out_px_d     = '0;
    out_py_d     = '0;
    out_pz_d     = '0;
    out_comp_d   = '0;
    out_value_d  = '0;
    out_last_d   = 1'b1;
    case (state_q)
      lgti_pkg::ST_CLEAR: begin
        mem_req.v_en   = 1'b1;
        mem_req.v_we   = 1'b1;
        mem_req.v_addr = clr_q;
        if (clr_q == lgti_pkg::PT_W'(lgti_pkg::NUM_POINTS - 1)) begin
          state_d = lgti_pkg::ST_IDLE;
        end
      end
      lgti_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (command_i == lgti_pkg::CMD_WRITE) begin
            if (in_grid) begin
              mem_req.v_en   = 1'b1;
              mem_req.v_addr = lgti_pkg::point_index(write_ix_i, write_iy_i, write_iz_i);
              state_d        = lgti_pkg::ST_WR_CHK;
            end else begin
              state_d = lgti_pkg::ST_EMIT_ONE;
            end
          end else begin
            state_d = lgti_pkg::ST_LOC_START;
          end
        end
      end
      lgti_pkg::ST_WR_CHK: begin
        if (!v_rdata) begin
          mem_req.s_en    = (4'(wcomp_q) < 4'(lgti_pkg::MAX_COMPONENTS));
          mem_req.s_we    = 1'b1;
          mem_req.s_addr  = lgti_pkg::sample_addr(
                              lgti_pkg::point_index(wix_q, wiy_q, wiz_q), wcomp_q);
          mem_req.s_wdata = sample_q;
          mem_req.v_en    = final_q;
          mem_req.v_we    = 1'b1;
          mem_req.v_addr  = lgti_pkg::point_index(wix_q, wiy_q, wiz_q);
          mem_req.v_wdata = 1'b1;
        end
        state_d = lgti_pkg::ST_EMIT_ONE;
      end
      lgti_pkg::ST_EMIT_ONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = lgti_pkg::ST_IDLE;
        end
      end
      lgti_pkg::ST_LOC_START: begin
        if (d_sel[32]) begin
          state_d = lgti_pkg::ST_EMIT_ONE;
        end else begin
          div_start = 1'b1;
          state_d   = lgti_pkg::ST_LOC_WAIT;
        end
      end
      lgti_pkg::ST_LOC_WAIT: begin
        if (div_done) begin
          if (div_quot[47:16] >= grid_m1) begin
            state_d = lgti_pkg::ST_EMIT_ONE;
          end else if (axis_q == 2'd2) begin
            state_d = lgti_pkg::ST_VCHK;
          end else begin
            state_d = lgti_pkg::ST_LOC_START;
          end
        end
      end
      lgti_pkg::ST_VCHK: begin
        if (!n_q[3]) begin
          mem_req.v_en   = 1'b1;
          mem_req.v_addr = lgti_pkg::point_index(vx, vy, vz);
        end else if ((&mask_q[6:0]) && v_rdata) begin
          state_d = lgti_pkg::ST_LOAD;
        end else begin
          state_d = lgti_pkg::ST_MISS;
        end
      end
      lgti_pkg::ST_MISS: begin
        out_status_d = lgti_pkg::STS_MISSING;
        out_ix_d     = mx;
        out_iy_d     = my;
        out_iz_d     = mz;
        out_px_d     = base_x_q + (nl[2] ? 32'(lgti_pkg::step_eff(step_x_q)) : 32'd0);
        out_py_d     = base_y_q + (nl[1] ? 32'(lgti_pkg::step_eff(step_y_q)) : 32'd0);
        out_pz_d     = base_z_q + (nl[0] ? 32'(lgti_pkg::step_eff(step_z_q)) : 32'd0);
        out_last_d   = miss_last;
        if (!mask_q[nl] && out_free) begin
          out_load = 1'b1;
          if (miss_last) begin
            state_d = lgti_pkg::ST_IDLE;
          end
        end
      end
      lgti_pkg::ST_LOAD: begin
        if (!n_q[3]) begin
          mem_req.s_en   = 1'b1;
          mem_req.s_addr = lgti_pkg::sample_addr(lgti_pkg::point_index(lx, ly, lz), comp_q);
        end else begin
          state_d = lgti_pkg::ST_BL_MUL;
        end
      end
      lgti_pkg::ST_BL_MUL: begin
        state_d = lgti_pkg::ST_BL_ADD;
      end
      lgti_pkg::ST_BL_ADD: begin
        state_d = (bc_q == 3'd6) ? lgti_pkg::ST_VAL_EMIT : lgti_pkg::ST_BL_MUL;
      end
      lgti_pkg::ST_VAL_EMIT: begin
        out_status_d = lgti_pkg::STS_VALUE;
        out_comp_d   = comp_q;
        out_value_d  = queue_q[0];
        out_last_d   = comp_last;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = comp_last ? lgti_pkg::ST_IDLE : lgti_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = lgti_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgti_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lgti_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_ix_q     <= out_ix_d;
      out_iy_q     <= out_iy_d;
      out_iz_q     <= out_iz_d;
      out_px_q     <= out_px_d;
      out_py_q     <= out_py_d;
      out_pz_q     <= out_pz_d;
      out_comp_q   <= out_comp_d;
      out_value_q  <= out_value_d;
      out_last_q   <= out_last_d;
    end
    case (state_q)
      lgti_pkg::ST_IDLE: begin
        pos_x_q  <= pos_x_i;
        pos_y_q  <= pos_y_i;
        pos_z_q  <= pos_z_i;
        wix_q    <= write_ix_i;
        wiy_q    <= write_iy_i;
        wiz_q    <= write_iz_i;
        wcomp_q  <= component_i;
        sample_q <= sample_i;
        final_q  <= final_component_i;
        axis_q   <= 2'd0;
        n_q      <= '0;
        status_q <= lgti_pkg::STS_RANGE;
      end
      lgti_pkg::ST_WR_CHK: begin
        status_q <= v_rdata ? lgti_pkg::STS_WR_REJECT : lgti_pkg::STS_WR_OK;
      end
      lgti_pkg::ST_LOC_WAIT: begin
        if (div_done) begin
          axis_q <= axis_q + 2'd1;
          case (axis_q)
            2'd0: begin
              cell_x_q <= div_quot[21:16];
              t_x_q    <= div_quot[15:0];
              base_x_q <= pos_x_q - 32'(div_rem);
            end
            2'd1: begin
              cell_y_q <= div_quot[21:16];
              t_y_q    <= div_quot[15:0];
              base_y_q <= pos_y_q - 32'(div_rem);
            end
            default: begin
              cell_z_q <= div_quot[21:16];
              t_z_q    <= div_quot[15:0];
              base_z_q <= pos_z_q - 32'(div_rem);
            end
          endcase
        end
      end
      lgti_pkg::ST_VCHK: begin
        if (n_q != 4'd0) begin
          mask_q[nm1] <= v_rdata;
        end
        if (n_q[3]) begin
          n_q    <= '0;
          comp_q <= '0;
        end else begin
          n_q <= n_q + 4'd1;
        end
      end
      lgti_pkg::ST_MISS: begin
        if (mask_q[nl] || out_free) begin
          n_q <= n_q + 4'd1;
        end
      end
      lgti_pkg::ST_LOAD: begin
        if (n_q != 4'd0) begin
          queue_q[nm1] <= s_rdata;
        end
        n_q    <= n_q + 4'd1;
        qcnt_q <= 4'd8;
        bc_q   <= '0;
      end
      lgti_pkg::ST_BL_MUL: begin
        a_q    <= queue_q[0];
        prod_q <= 50'($signed(diff) * $signed({1'b0, t_sel}));
        for (int i = 0; i < 6; i++) begin
          queue_q[i] <= queue_q[i+2];
        end
        qcnt_q <= qcnt_q - 4'd2;
      end
      lgti_pkg::ST_BL_ADD: begin
        queue_q[qcnt_q[2:0]] <= blend_res;
        qcnt_q <= qcnt_q + 4'd1;
        bc_q   <= bc_q + 3'd1;
      end
      lgti_pkg::ST_VAL_EMIT: begin
        if (out_free) begin
          comp_q <= comp_q + 3'd1;
          n_q    <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  lgti_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({d_sel[31:0], 16'd0}),
    .divisor_i  (step_sel),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_mid_o  (div_rem)
  );

  lgti_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .v_rdata_o (v_rdata),
    .s_rdata_o (s_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign corner_ix_o     = out_ix_q;
  assign corner_iy_o     = out_iy_q;
  assign corner_iz_o     = out_iz_q;
  assign corner_pos_x_o  = out_px_q;
  assign corner_pos_y_o  = out_py_q;
  assign corner_pos_z_o  = out_pz_q;
  assign out_component_o = out_comp_q;
  assign result_value_o  = out_value_q;
  assign last_o          = out_last_q;

endmodule

FILE: hw/rtl/lgti_div.sv
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// Divides a 48-bit dividend by a 31-bit divisor, one quotient bit per cycle,
// and keeps the remainder seen after the integer part of the quotient.
// ----------------------------------------------------------------------------
module lgti_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lgti_pkg::NUM_W-1:0]   dividend_i,
  input  logic [lgti_pkg::DEN_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [lgti_pkg::NUM_W-1:0]   quot_o,
  output logic [lgti_pkg::DEN_W-1:0]   rem_mid_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [lgti_pkg::CNT_W-1:0]   cnt_q;
  logic [lgti_pkg::NUM_W-1:0]   num_q;
  logic [lgti_pkg::DEN_W-1:0]   den_q;
  logic [lgti_pkg::DEN_W-1:0]   rem_q;
  logic [lgti_pkg::DEN_W-1:0]   rem_mid_q;
  logic [lgti_pkg::DEN_W:0]     rem_sh;
  logic                         qbit;
  logic [lgti_pkg::DEN_W-1:0]   rem_new;

  always_comb begin
    rem_sh  = {rem_q, num_q[lgti_pkg::NUM_W-1]};
    qbit    = (rem_sh >= {1'b0, den_q});
    rem_new = qbit ? lgti_pkg::DEN_W'(rem_sh - {1'b0, den_q})
                   : lgti_pkg::DEN_W'(rem_sh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == lgti_pkg::CNT_W'(lgti_pkg::NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[lgti_pkg::NUM_W-2:0], qbit};
      rem_q <= rem_new;
      if (cnt_q == lgti_pkg::CNT_W'(lgti_pkg::MID_ITER - 1)) begin
        rem_mid_q <= rem_new;
      end
    end
  end

  assign done_o    = done_q;
  assign quot_o    = num_q;
  assign rem_mid_o = rem_mid_q;

endmodule

FILE: hw/rtl/lgti_mem.sv
// ----------------------------------------------------------------------------
// Grid storage
// Point valid marks and component samples, each a single-port memory with a
// registered read.
// ----------------------------------------------------------------------------
module lgti_mem (
  input  logic                clk_i,
  input  lgti_pkg::mem_req_t  req_i,
  output logic                v_rdata_o,
  output logic [31:0]         s_rdata_o
);

  logic        valid_mem [lgti_pkg::NUM_POINTS];
  logic [31:0] sample_mem [lgti_pkg::NUM_SAMPLES];

  always_ff @(posedge clk_i) begin
    if (req_i.v_en) begin
      if (req_i.v_we) begin
        valid_mem[req_i.v_addr] <= req_i.v_wdata;
      end
      v_rdata_o <= valid_mem[req_i.v_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.s_en) begin
      if (req_i.s_we) begin
        sample_mem[req_i.s_addr] <= req_i.s_wdata;
      end
      s_rdata_o <= sample_mem[req_i.s_addr];
    end
  end

endmodule

FILE: hw/rtl/lgti_checker.sv
// ----------------------------------------------------------------------------
// Lazy grid trilinear interpolator checker
// Port-level checks on the request and result channels.
// ----------------------------------------------------------------------------
module lgti_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [5:0]  corner_ix_o,
  input logic [2:0]  out_component_o,
  input logic [31:0] result_value_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a request while busy");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == lgti_pkg::STS_WR_OK || status_o == lgti_pkg::STS_WR_REJECT
      || status_o == lgti_pkg::STS_RANGE) |-> last_o)
    else $error("single result without last");

  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == lgti_pkg::STS_MISSING |->
      out_component_o == 3'd0 && result_value_o == 32'd0)
    else $error("value fields set on missing corner");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == lgti_pkg::STS_VALUE |-> corner_ix_o == 6'd0)
    else $error("corner fields set on value");

endmodule

bind lazy_grid_trilinear_interpolator_unit lgti_checker u_lgti_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .corner_ix_o     (corner_ix_o),
  .out_component_o (out_component_o),
  .result_value_o  (result_value_o),
  .last_o          (last_o)
);

FILE: sim/lazy_grid_trilinear_interpolator_unit_tb.sv
// ----------------------------------------------------------------------------
// Lazy grid trilinear interpolator testbench
// Drives write and evaluate requests across four register settings, under
// random idling on both sides in the first two, predicts every result in a
// local grid model and checks each result field by field in order.
// ----------------------------------------------------------------------------
module lazy_grid_trilinear_interpolator_unit_tb;

  localparam int RUN_LIMIT = 1000000;
  localparam int PHASE_REQS = 56;

  typedef struct {
    lgti_pkg::cmd_e cmd;
    logic [31:0]    px, py, pz;
    logic [5:0]     ix, iy, iz;
    logic [2:0]     comp;
    logic [31:0]    smp;
    logic           fin;
  } grid_req_t;

  typedef struct {
    lgti_pkg::status_e st;
    logic [5:0]        cx, cy, cz;
    logic [31:0]       cpx, cpy, cpz;
    logic [2:0]        comp;
    logic [31:0]       val;
    logic              last;
  } grid_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  grid_req_t   cur_req = '{lgti_pkg::CMD_WRITE, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0};
  logic [2:0]  status;
  logic [5:0]  corner_ix, corner_iy, corner_iz;
  logic [31:0] corner_pos_x, corner_pos_y, corner_pos_z;
  logic [2:0]  out_component;
  logic [31:0] result_value;
  logic        last;

  lazy_grid_trilinear_interpolator_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(cur_req.cmd), .pos_x_i(cur_req.px), .pos_y_i(cur_req.py),
    .pos_z_i(cur_req.pz), .write_ix_i(cur_req.ix), .write_iy_i(cur_req.iy),
    .write_iz_i(cur_req.iz), .component_i(cur_req.comp), .sample_i(cur_req.smp),
    .final_component_i(cur_req.fin),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .corner_ix_o(corner_ix), .corner_iy_o(corner_iy),
    .corner_iz_o(corner_iz), .corner_pos_x_o(corner_pos_x),
    .corner_pos_y_o(corner_pos_y), .corner_pos_z_o(corner_pos_z),
    .out_component_o(out_component), .result_value_o(result_value), .last_o(last)
  );

  // Register copy, grid model and the expected result store.
  logic signed [31:0] org_x = 0, org_y = 0, org_z = 0;
  logic [30:0]        stp_x = 65536, stp_y = 65536, stp_z = 65536;
  logic [3:0]         comps_cfg = 1;
  logic               pt_valid [lgti_pkg::NUM_POINTS];
  logic [31:0]        pt_sample [lgti_pkg::NUM_SAMPLES];
  grid_result_t       pending_results [$];
  grid_req_t          request_q [$];

  // Generation-side view of the grid, advanced as requests are queued.
  logic       plan_valid [lgti_pkg::NUM_POINTS];
  logic [7:0] plan_mask [lgti_pkg::NUM_POINTS];

  int send_idle = 0, recv_idle = 0;
  int mismatches = 0, cycles = 0, n_reqs = 0, n_results = 0, n_values = 0, n_missing = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pt_of(int x, int y, int z);
    return (x * lgti_pkg::GRID_Y + y) * lgti_pkg::GRID_Z + z;
  endfunction

  function automatic longint eff_step(logic [30:0] s);
    return (s == '0) ? 64'sd1 : longint'(s);
  endfunction

  function automatic bit find_cell(logic [31:0] p, logic signed [31:0] o, logic [30:0] s,
                                   int n, output int cell_idx, output longint frac);
    longint d, se, q;
    se = eff_step(s);
    d = longint'($signed(p)) - longint'(o);
    cell_idx = 0;
    frac = 0;
    if (d < 0) return 1'b0;
    q = d / se;
    if (q >= n - 1) return 1'b0;
    cell_idx = int'(q);
    frac = ((d - q * se) <<< 16) / se;
    return 1'b1;
  endfunction

  function automatic longint lerp_q16(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> 16);
  endfunction

  function automatic grid_result_t plain_result(lgti_pkg::status_e st);
    grid_result_t r;
    r = '{st, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0};
    return r;
  endfunction

  task automatic predict_request(grid_req_t q);
    grid_result_t r;
    int cx, cy, cz, pt, nc, first;
    longint tx, ty, tz, e[2][2], f[2], v[2][2][2];
    bit okx, oky, okz;
    if (q.cmd == lgti_pkg::CMD_WRITE) begin
      if (q.ix >= lgti_pkg::GRID_X || q.iy >= lgti_pkg::GRID_Y || q.iz >= lgti_pkg::GRID_Z)
      begin
        r = plain_result(lgti_pkg::STS_RANGE);
      end else begin
        pt = pt_of(q.ix, q.iy, q.iz);
        if (pt_valid[pt]) begin
          r = plain_result(lgti_pkg::STS_WR_REJECT);
        end else begin
          pt_sample[pt * lgti_pkg::MAX_COMPONENTS + q.comp] = q.smp;
          if (q.fin) pt_valid[pt] = 1'b1;
          r = plain_result(lgti_pkg::STS_WR_OK);
        end
      end
      r.last = 1'b1;
      pending_results.push_back(r);
      return;
    end
    okx = find_cell(q.px, org_x, stp_x, lgti_pkg::GRID_X, cx, tx);
    oky = find_cell(q.py, org_y, stp_y, lgti_pkg::GRID_Y, cy, ty);
    okz = find_cell(q.pz, org_z, stp_z, lgti_pkg::GRID_Z, cz, tz);
    if (!(okx && oky && okz)) begin
      r = plain_result(lgti_pkg::STS_RANGE);
      r.last = 1'b1;
      pending_results.push_back(r);
      return;
    end
    first = pending_results.size();
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        for (int k = 0; k < 2; k++) begin
          if (!pt_valid[pt_of(cx + i, cy + j, cz + k)]) begin
            r = plain_result(lgti_pkg::STS_MISSING);
            r.cx = 6'(cx + i);
            r.cy = 6'(cy + j);
            r.cz = 6'(cz + k);
            r.cpx = 32'(longint'(org_x) + (cx + i) * eff_step(stp_x));
            r.cpy = 32'(longint'(org_y) + (cy + j) * eff_step(stp_y));
            r.cpz = 32'(longint'(org_z) + (cz + k) * eff_step(stp_z));
            pending_results.push_back(r);
          end
        end
    if (pending_results.size() == first) begin
      nc = (comps_cfg == 0) ? 1 :
           (comps_cfg > lgti_pkg::MAX_COMPONENTS) ? lgti_pkg::MAX_COMPONENTS : comps_cfg;
      for (int c = 0; c < nc; c++) begin
        for (int i = 0; i < 2; i++)
          for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++)
              v[i][j][k] = longint'($signed(
                  pt_sample[pt_of(cx + i, cy + j, cz + k) * lgti_pkg::MAX_COMPONENTS + c]));
        for (int j = 0; j < 2; j++)
          for (int k = 0; k < 2; k++)
            e[j][k] = lerp_q16(v[0][j][k], v[1][j][k], tx);
        for (int k = 0; k < 2; k++)
          f[k] = lerp_q16(e[0][k], e[1][k], ty);
        r = plain_result(lgti_pkg::STS_VALUE);
        r.comp = 3'(c);
        r.val = 32'(lerp_q16(f[0], f[1], tz));
        pending_results.push_back(r);
      end
    end
    pending_results[pending_results.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Request driver.
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid || !in_stall)) begin
      if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        cur_req <= request_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    grid_result_t e;
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("[lazy_grid_trilinear_interpolator_unit] ERROR");
      $finish;
    end
    if (rst_ni) begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
      if (in_valid && !in_stall) predict_request(cur_req);
      if (out_valid && !out_stall) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $error("unexpected result with status %0d", status);
          mismatches++;
        end else begin
          e = pending_results.pop_front();
          if (e.st == lgti_pkg::STS_VALUE) n_values++;
          if (e.st == lgti_pkg::STS_MISSING) n_missing++;
          check_field("status", e.st, status);
          check_field("corner_ix", e.cx, corner_ix);
          check_field("corner_iy", e.cy, corner_iy);
          check_field("corner_iz", e.cz, corner_iz);
          check_field("corner_pos_x", e.cpx, corner_pos_x);
          check_field("corner_pos_y", e.cpy, corner_pos_y);
          check_field("corner_pos_z", e.cpz, corner_pos_z);
          check_field("out_component", e.comp, out_component);
          check_field("result_value", e.val, result_value);
          check_field("last", e.last, last);
        end
      end
    end
  end

  task automatic write_reg(lgti_pkg::cfg_idx_e idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lgti_pkg::CFG_ORIGIN_X:   org_x = data;
      lgti_pkg::CFG_ORIGIN_Y:   org_y = data;
      lgti_pkg::CFG_ORIGIN_Z:   org_z = data;
      lgti_pkg::CFG_STEP_X:     stp_x = data[30:0];
      lgti_pkg::CFG_STEP_Y:     stp_y = data[30:0];
      lgti_pkg::CFG_STEP_Z:     stp_z = data[30:0];
      lgti_pkg::CFG_COMPONENTS: comps_cfg = data[3:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    do @(posedge clk_i); while (request_q.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic queue_write(int x, int y, int z, int comp, logic [31:0] smp, logic fin);
    grid_req_t q;
    int pt;
    q = '{lgti_pkg::CMD_WRITE, $urandom(), $urandom(), $urandom(), 6'(x), 6'(y), 6'(z),
          3'(comp), smp, fin};
    if (x < lgti_pkg::GRID_X && y < lgti_pkg::GRID_Y && z < lgti_pkg::GRID_Z) begin
      pt = pt_of(x, y, z);
      if (!plan_valid[pt]) begin
        plan_mask[pt] |= 8'(1 << comp);
        if (fin) plan_valid[pt] = 1'b1;
      end
    end
    request_q.push_back(q);
    n_reqs++;
  endtask

  task automatic queue_eval(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    request_q.push_back('{lgti_pkg::CMD_EVAL, x, y, z, 6'($urandom()), 6'($urandom()),
                          6'($urandom()), 3'($urandom()), $urandom(), 1'($urandom())});
    n_reqs++;
  endtask

  function automatic logic [31:0] pos_in(logic signed [31:0] o, logic [30:0] s, int cell_idx);
    longint se;
    se = eff_step(s);
    return 32'(longint'(o) + cell_idx * se + longint'($urandom_range(32'(se - 1), 0)));
  endfunction

  task automatic queue_cell_eval(int cx, int cy, int cz);
    queue_eval(pos_in(org_x, stp_x, cx), pos_in(org_y, stp_y, cy), pos_in(org_z, stp_z, cz));
  endtask

  // Every component is written before a point is marked valid.
  task automatic fill_point(int x, int y, int z);
    if (!plan_valid[pt_of(x, y, z)])
      for (int c = 0; c < lgti_pkg::MAX_COMPONENTS; c++)
        queue_write(x, y, z, c, $urandom(), c == 7);
  endtask

  task automatic queue_noise_write();
    int x, y, z, c, pt;
    logic fin;
    x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
    y = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
    z = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
    c = $urandom_range(0, 7);
    fin = 1'($urandom());
    if (x < lgti_pkg::GRID_X && y < lgti_pkg::GRID_Y && z < lgti_pkg::GRID_Z) begin
      pt = pt_of(x, y, z);
      if (!plan_valid[pt] && (plan_mask[pt] | 8'(1 << c)) != 8'hff) fin = 1'b0;
    end
    queue_write(x, y, z, c, $urandom(), fin);
  endtask

  task automatic queue_random(int count);
    int goal, cx, cy, cz, pick;
    goal = n_reqs + count;
    while (n_reqs < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        cx = $urandom_range(0, 1);
        cy = $urandom_range(0, 1);
        cz = $urandom_range(0, 1);
        queue_cell_eval(cx, cy, cz);
        for (int i = 0; i < 2; i++)
          for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++) fill_point(cx + i, cy + j, cz + k);
        repeat ($urandom_range(1, 3)) queue_cell_eval(cx, cy, cz);
      end else if (pick < 8) begin
        queue_noise_write();
      end else if (pick == 8) begin
        queue_eval($urandom(), $urandom(), $urandom());
      end else begin
        queue_cell_eval($urandom_range(0, 14), $urandom_range(0, 14), $urandom_range(0, 14));
      end
    end
  endtask

  initial begin
    for (int p = 0; p < lgti_pkg::NUM_POINTS; p++) begin
      pt_valid[p] = 1'b0;
      plan_valid[p] = 1'b0;
      plan_mask[p] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 0) ? 38 : (phase == 1) ? 58 : 0;
      recv_idle = (phase == 0) ? 58 : (phase == 1) ? 38 : 0;
      case (phase)
        0: begin
          write_reg(lgti_pkg::CFG_ORIGIN_X, 0);
          write_reg(lgti_pkg::CFG_ORIGIN_Y, 0);
          write_reg(lgti_pkg::CFG_ORIGIN_Z, 0);
          write_reg(lgti_pkg::CFG_STEP_X, 65536);
          write_reg(lgti_pkg::CFG_STEP_Y, 65536);
          write_reg(lgti_pkg::CFG_STEP_Z, 65536);
          write_reg(lgti_pkg::CFG_COMPONENTS, 3);
        end
        1: begin
          write_reg(lgti_pkg::CFG_ORIGIN_X, 32'h8000_0000);
          write_reg(lgti_pkg::CFG_ORIGIN_Y, 32'h7fff_ffff);
          write_reg(lgti_pkg::CFG_ORIGIN_Z, -70000);
          write_reg(lgti_pkg::CFG_STEP_X, 0);
          write_reg(lgti_pkg::CFG_STEP_Y, 32'h7fff_ffff);
          write_reg(lgti_pkg::CFG_STEP_Z, 3 * 65536 + 7);
          write_reg(lgti_pkg::CFG_COMPONENTS, 8);
        end
        2: begin
          write_reg(lgti_pkg::CFG_ORIGIN_X, $urandom_range(0, 1 << 20) - (1 << 19));
          write_reg(lgti_pkg::CFG_ORIGIN_Y, $urandom_range(0, 1 << 20) - (1 << 19));
          write_reg(lgti_pkg::CFG_ORIGIN_Z, $urandom_range(0, 1 << 20) - (1 << 19));
          write_reg(lgti_pkg::CFG_STEP_X, $urandom_range(1, 1 << 20));
          write_reg(lgti_pkg::CFG_STEP_Y, $urandom_range(1, 1 << 20));
          write_reg(lgti_pkg::CFG_STEP_Z, $urandom_range(1, 1 << 20));
          write_reg(lgti_pkg::CFG_COMPONENTS, 0);
        end
        default: begin
          write_reg(lgti_pkg::CFG_ORIGIN_X, 32'hffff_0000);
          write_reg(lgti_pkg::CFG_STEP_X, 1);
          write_reg(lgti_pkg::CFG_STEP_Y, 40000);
          write_reg(lgti_pkg::CFG_STEP_Z, 1);
          write_reg(lgti_pkg::CFG_COMPONENTS, 15);
        end
      endcase

      if (phase == 0) begin
        // Writes outside the grid, evaluations outside it and at the upper
        // boundary, an empty cell, and a rejected write to a filled point.
        queue_write(63, 0, 0, 0, 32'h7fff_ffff, 1'b1);
        queue_write(0, 63, 0, 7, 32'h8000_0000, 1'b0);
        queue_write(0, 0, 16, 0, 0, 1'b1);
        queue_eval(32'hffff_ffff, 0, 0);
        queue_eval(0, 32'h0000_0000 + 15 * 65536, 0);
        queue_eval(32'h7fff_ffff, 32'h8000_0000, 0);
        queue_eval(5 * 65536, 5 * 65536, 5 * 65536 + 32768);
        fill_point(15, 15, 15);
        queue_write(15, 15, 15, 3, 32'h1234_5678, 1'b1);
        queue_eval(14 * 65536 + 65535, 14 * 65536, 14 * 65536 + 1);
      end

      queue_random(PHASE_REQS / 2);
      if (phase == 1) drain();
      queue_random(PHASE_REQS - PHASE_REQS / 2);
      drain();
    end

    $display("Ran %0d requests over four register settings; %0d results checked.",
             n_reqs, n_results);
    $display("Results included %0d interpolated values and %0d missing corners.",
             n_values, n_missing);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[lazy_grid_trilinear_interpolator_unit] OK");
    end else begin
      $display("[lazy_grid_trilinear_interpolator_unit] ERROR");
    end
    $finish;
  end

endmodule
